// File: hdl/mqttps_pkg.sv
// Types, codes and the property-ID type map of the MQTT 5 property section parser.
// No dependencies; used by the step logic, the top level and the testbench.
package mqttps_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_ID,
    PH_NUM,
    PH_VBI,
    PH_SLEN_HI,
    PH_SLEN_LO,
    PH_BODY
  } phase_e;

  // Property encoding class
  typedef enum logic [2:0] {
    PT_UNKNOWN,
    PT_BYTE1,
    PT_BYTE2,
    PT_BYTE4,
    PT_VBI,
    PT_STR,
    PT_PAIR
  } ptype_e;

  // Result kind
  typedef enum logic [1:0] {
    KIND_VALUE,
    KIND_PAYLOAD,
    KIND_EMPTY,
    KIND_STATUS
  } kind_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK,
    ST_MALFORMED,
    ST_PROTO_ERR
  } status_e;

  // What one byte leads to, before the section-end rules are applied
  typedef enum logic [2:0] {
    OC_NONE,
    OC_EMPTY_SECTION,
    OC_ERR_MAL,
    OC_ERR_PROTO,
    OC_FINISH,
    OC_STR_END,
    OC_SECOND,
    OC_BODY
  } outcome_e;

  localparam logic [7:0]  USER_PROP_ID = 8'h26;
  localparam logic [7:0]  VBI_MASK     = 8'h7f;
  localparam logic [7:0]  VBI_CONT     = 8'h80;
  localparam logic [2:0]  VBI_MAX_BYTES = 3'd4;

  typedef struct packed {
    phase_e      phase;
    logic [27:0] section_left;
    logic [7:0]  current_id;
    logic [31:0] acc;
    logic [2:0]  byte_count;
    logic [15:0] string_left;
    logic        in_second;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  prop_id;
    logic [31:0] value;
    logic [7:0]  payload_byte;
    logic        second_string;
    logic        last_of_property;
    logic        section_done;
    status_e     status;
  } result_t;

  // Identifier-to-type map of the standard
  function automatic ptype_e prop_type(input logic [7:0] id);
    ptype_e t;
    case (id)
      8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: t = PT_BYTE1;
      8'h13, 8'h21, 8'h22, 8'h23:                             t = PT_BYTE2;
      8'h02, 8'h11, 8'h18, 8'h27:                             t = PT_BYTE4;
      8'h0B:                                                  t = PT_VBI;
      8'h03, 8'h08, 8'h09, 8'h12, 8'h15, 8'h16, 8'h1A, 8'h1C, 8'h1F:
                                                              t = PT_STR;
      USER_PROP_ID:                                           t = PT_PAIR;
      default:                                                t = PT_UNKNOWN;
    endcase
    return t;
  endfunction

  // Weighted 7-bit group of a variable byte integer
  function automatic logic [31:0] vbi_term(input logic [7:0] b, input logic [1:0] pos);
    logic [31:0] g;
    logic [31:0] t;
    g = {24'd0, b & VBI_MASK};
    case (pos)
      2'd0:    t = g;
      2'd1:    t = g << 7;
      2'd2:    t = g << 14;
      default: t = g << 21;
    endcase
    return t;
  endfunction

endpackage

// File: hdl/mqttps_if.sv
// Valid/ready channel interfaces of the MQTT 5 property section parser.
// Depends on nothing; field widths follow the parser's item layout.
interface mqttps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, data_byte, start_req, input ready);
  modport sink   (input valid, data_byte, start_req, output ready);
endinterface

interface mqttps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  prop_id;
  logic [31:0] value;
  logic [7:0]  payload_byte;
  logic        second_string;
  logic        last_of_property;
  logic        section_done;
  logic [1:0]  status;

  modport source (output valid, kind, prop_id, value, payload_byte, second_string,
                  last_of_property, section_done, status, input ready);
  modport sink   (input valid, kind, prop_id, value, payload_byte, second_string,
                  last_of_property, section_done, status, output ready);
endinterface

// File: hdl/mqttps_step.sv
// Next-state and result logic for one section byte of the property parser.
// Depends on mqttps_pkg (state, result, phase and kind types, type map).
module mqttps_step (
  input  mqttps_pkg::state_t  st_i,
  input  logic [7:0]          data_byte_i,
  input  logic                start_req_i,
  output mqttps_pkg::state_t  st_o,
  output logic                hit_o,
  output mqttps_pkg::result_t res_o
);

  mqttps_pkg::state_t   s;
  mqttps_pkg::outcome_e oc;
  mqttps_pkg::ptype_e   pt;
  mqttps_pkg::kind_e    kd;
  mqttps_pkg::status_e  stat;
  logic [7:0]           pb;
  logic                 tail_chk;
  logic                 second;
  logic                 last;
  logic                 done;
  logic                 hit;

  always_comb begin
    s        = st_i;
    oc       = mqttps_pkg::OC_NONE;
    pt       = mqttps_pkg::prop_type(data_byte_i);
    kd       = mqttps_pkg::KIND_STATUS;
    stat     = mqttps_pkg::ST_OK;
    pb       = data_byte_i;
    tail_chk = 1'b0;
    second   = 1'b0;
    last     = 1'b0;
    done     = 1'b0;
    hit      = 1'b0;

    // restart: drop all progress
    if (start_req_i) begin
      s.phase        = mqttps_pkg::PH_LEN;
      s.section_left = '0;
      s.current_id   = '0;
      s.acc          = '0;
      s.byte_count   = '0;
      s.string_left  = '0;
      s.in_second    = 1'b0;
    end

    // per-phase byte handling
    if (s.phase == mqttps_pkg::PH_LEN) begin
      s.acc        = s.acc + mqttps_pkg::vbi_term(data_byte_i, s.byte_count[1:0]);
      s.byte_count = s.byte_count + 3'd1;
      if ((data_byte_i & mqttps_pkg::VBI_CONT) != 8'd0) begin
        if (s.byte_count >= mqttps_pkg::VBI_MAX_BYTES) oc = mqttps_pkg::OC_ERR_MAL;
      end else begin
        s.section_left = s.acc[27:0];
        s.acc          = '0;
        s.byte_count   = '0;
        if (s.section_left == 28'd0) oc = mqttps_pkg::OC_EMPTY_SECTION;
        else s.phase = mqttps_pkg::PH_ID;
      end
    end else if (s.phase != mqttps_pkg::PH_IDLE) begin
      if (s.section_left == 28'd0) begin
        oc = mqttps_pkg::OC_ERR_MAL;
      end else begin
        s.section_left = s.section_left - 28'd1;
        unique case (s.phase)
          mqttps_pkg::PH_ID: begin
            s.current_id = data_byte_i;
            s.acc        = '0;
            s.byte_count = '0;
            s.in_second  = 1'b0;
            tail_chk     = 1'b1;
            case (pt)
              mqttps_pkg::PT_BYTE1: begin
                s.byte_count = 3'd1;
                s.phase      = mqttps_pkg::PH_NUM;
              end
              mqttps_pkg::PT_BYTE2: begin
                s.byte_count = 3'd2;
                s.phase      = mqttps_pkg::PH_NUM;
              end
              mqttps_pkg::PT_BYTE4: begin
                s.byte_count = 3'd4;
                s.phase      = mqttps_pkg::PH_NUM;
              end
              mqttps_pkg::PT_VBI:                    s.phase = mqttps_pkg::PH_VBI;
              mqttps_pkg::PT_STR, mqttps_pkg::PT_PAIR: s.phase = mqttps_pkg::PH_SLEN_HI;
              default:                               oc = mqttps_pkg::OC_ERR_PROTO;
            endcase
          end
          mqttps_pkg::PH_NUM: begin
            s.acc        = {s.acc[23:0], data_byte_i};
            s.byte_count = s.byte_count - 3'd1;
            kd           = mqttps_pkg::KIND_VALUE;
            if (s.byte_count == 3'd0) oc = mqttps_pkg::OC_FINISH;
            else tail_chk = 1'b1;
          end
          mqttps_pkg::PH_VBI: begin
            s.acc        = s.acc + mqttps_pkg::vbi_term(data_byte_i, s.byte_count[1:0]);
            s.byte_count = s.byte_count + 3'd1;
            kd           = mqttps_pkg::KIND_VALUE;
            if ((data_byte_i & mqttps_pkg::VBI_CONT) == 8'd0) oc = mqttps_pkg::OC_FINISH;
            else if (s.byte_count >= mqttps_pkg::VBI_MAX_BYTES) oc = mqttps_pkg::OC_ERR_MAL;
            else tail_chk = 1'b1;
          end
          mqttps_pkg::PH_SLEN_HI: begin
            s.string_left = {data_byte_i, 8'd0};
            s.phase       = mqttps_pkg::PH_SLEN_LO;
            tail_chk      = 1'b1;
          end
          mqttps_pkg::PH_SLEN_LO: begin
            s.string_left = {s.string_left[15:8], data_byte_i};
            kd            = mqttps_pkg::KIND_EMPTY;
            if (s.string_left == 16'd0) begin
              oc = mqttps_pkg::OC_STR_END;
            end else begin
              s.phase  = mqttps_pkg::PH_BODY;
              tail_chk = 1'b1;
            end
          end
          mqttps_pkg::PH_BODY: begin
            s.string_left = s.string_left - 16'd1;
            kd            = mqttps_pkg::KIND_PAYLOAD;
            if (s.string_left == 16'd0)        oc = mqttps_pkg::OC_STR_END;
            else if (s.section_left == 28'd0)  oc = mqttps_pkg::OC_ERR_MAL;
            else                               oc = mqttps_pkg::OC_BODY;
          end
          default: s.phase = mqttps_pkg::PH_IDLE;
        endcase
      end
    end

    // overrun: property still needs bytes but the section is used up
    if (oc == mqttps_pkg::OC_NONE && tail_chk && s.section_left == 28'd0) begin
      oc = mqttps_pkg::OC_ERR_MAL;
    end

    // end of a string: a user property's key string is followed by its value
    if (oc == mqttps_pkg::OC_STR_END) begin
      if (s.current_id == mqttps_pkg::USER_PROP_ID && !s.in_second) begin
        if (s.section_left == 28'd0) oc = mqttps_pkg::OC_ERR_MAL;
        else oc = mqttps_pkg::OC_SECOND;
      end else begin
        oc = mqttps_pkg::OC_FINISH;
      end
    end

    // result fields and closing phase
    unique case (oc)
      mqttps_pkg::OC_NONE: hit = 1'b0;
      mqttps_pkg::OC_EMPTY_SECTION: begin
        hit     = 1'b1;
        kd      = mqttps_pkg::KIND_STATUS;
        done    = 1'b1;
        s.phase = mqttps_pkg::PH_IDLE;
      end
      mqttps_pkg::OC_ERR_MAL, mqttps_pkg::OC_ERR_PROTO: begin
        hit     = 1'b1;
        kd      = mqttps_pkg::KIND_STATUS;
        done    = 1'b1;
        stat    = (oc == mqttps_pkg::OC_ERR_MAL) ? mqttps_pkg::ST_MALFORMED
                                                 : mqttps_pkg::ST_PROTO_ERR;
        s.phase = mqttps_pkg::PH_IDLE;
      end
      mqttps_pkg::OC_FINISH: begin
        hit     = 1'b1;
        last    = 1'b1;
        done    = (s.section_left == 28'd0);
        second  = (kd != mqttps_pkg::KIND_VALUE) ? s.in_second : 1'b0;
        s.phase = done ? mqttps_pkg::PH_IDLE : mqttps_pkg::PH_ID;
      end
      mqttps_pkg::OC_SECOND: begin
        hit         = 1'b1;
        s.phase     = mqttps_pkg::PH_SLEN_HI;
        s.in_second = 1'b1;
      end
      mqttps_pkg::OC_BODY: begin
        hit    = 1'b1;
        second = s.in_second;
      end
      default: hit = 1'b0;
    endcase

    res_o.kind             = kd;
    res_o.prop_id          = s.current_id;
    res_o.value            = (kd == mqttps_pkg::KIND_VALUE) ? s.acc : 32'd0;
    res_o.payload_byte     = (kd == mqttps_pkg::KIND_PAYLOAD) ? pb : 8'd0;
    res_o.second_string    = second;
    res_o.last_of_property = last;
    res_o.section_done     = done;
    res_o.status           = stat;
    st_o                   = s;
    hit_o                  = hit;
  end

endmodule

// File: hdl/mqtt5_property_section_parser.sv
// MQTT 5 property section parser, one section byte per beat.
// Result path: input register, then the combinational step, then the result register.
// Throughput: 1 byte per cycle unless results stall; parse state updates in the single step between registers.
// Reset (rst_ni low, asynchronous): both stages empty, parser idle with cleared state.
// Depends on mqttps_pkg, mqttps_if (channel interfaces) and mqttps_step.
module mqtt5_property_section_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  mqttps_in_if.sink    in_i,
  mqttps_out_if.source out_o
);

  logic                in_valid_q;
  logic [7:0]          data_q;
  logic                start_q;
  logic                out_valid_q;
  mqttps_pkg::result_t res_q;
  mqttps_pkg::state_t  st_q;
  mqttps_pkg::state_t  st_d;
  mqttps_pkg::result_t res_d;
  logic                hit;
  logic                out_free;
  logic                step_go;

  // handshake: output register frees the step, step frees the input register
  assign out_free  = !out_valid_q || out_o.ready;
  assign step_go   = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  mqttps_step u_step (
    .st_i        (st_q),
    .data_byte_i (data_q),
    .start_req_i (start_q),
    .st_o        (st_d),
    .hit_o       (hit),
    .res_o       (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q  <= in_i.data_byte;
      start_q <= in_i.start_req;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase        <= mqttps_pkg::PH_IDLE;
      st_q.section_left <= '0;
      st_q.current_id   <= '0;
      st_q.acc          <= '0;
      st_q.byte_count   <= '0;
      st_q.string_left  <= '0;
      st_q.in_second    <= 1'b0;
    end else if (step_go) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_go && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && hit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = res_q.kind;
  assign out_o.prop_id          = res_q.prop_id;
  assign out_o.value            = res_q.value;
  assign out_o.payload_byte     = res_q.payload_byte;
  assign out_o.second_string    = res_q.second_string;
  assign out_o.last_of_property = res_q.last_of_property;
  assign out_o.section_done     = res_q.section_done;
  assign out_o.status           = res_q.status;

`ifndef SYNTHESIS
  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // any error status ends the section
  a_error_ends_section: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != mqttps_pkg::ST_OK) |-> res_q.section_done)
    else $error("error result without section end");

  // a status-only result never closes a property
  a_status_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == mqttps_pkg::KIND_STATUS) |-> !res_q.last_of_property)
    else $error("status result marked as last of property");

  // section end leaves the parser idle
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && hit && res_d.section_done) |=> (st_q.phase == mqttps_pkg::PH_IDLE))
    else $error("parser not idle after section end");
`endif

endmodule

// File: tb/sv/mqtt5_property_section_parser_tb.sv
`timescale 1ns / 1ps
// Testbench for mqtt5_property_section_parser: directed rows, then random property sections.
// Each result beat is checked against a written row expectation or an in-bench parse model.
// Depends on mqttps_pkg, mqttps_if and the parser top level.
module mqtt5_property_section_parser_tb;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int ITEM_TARGET = 1400;
  localparam int SETTLE_CYCLES = 64;

  // Property IDs defined by the standard
  localparam logic [7:0] KNOWN_IDS [27] = '{
    8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A,
    8'h13, 8'h21, 8'h22, 8'h23,
    8'h02, 8'h11, 8'h18, 8'h27,
    8'h0B,
    8'h03, 8'h08, 8'h09, 8'h12, 8'h15, 8'h16, 8'h1A, 8'h1C, 8'h1F,
    mqttps_pkg::USER_PROP_ID
  };

  typedef struct {
    logic [7:0]          data;
    logic                start;
    bit                  typed;   // expectation written out in the row
    bit                  yields;  // typed row gives a result beat
    mqttps_pkg::result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mqttps_in_if  byte_ch ();
  mqttps_out_if res_ch ();

  mqtt5_property_section_parser u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  // Parse model state
  mqttps_pkg::phase_e sec_phase;
  logic [27:0]        sec_left;
  logic [7:0]         cur_id;
  logic [31:0]        num_acc;
  logic [2:0]         num_cnt;
  logic [15:0]        str_left;
  logic               in_value_str;

  mqttps_pkg::result_t expected_q [$];
  logic [7:0]          sec_bytes [$];
  stim_row_t           dir_rows [26];
  int                  n_errors;
  int                  n_results;
  int                  n_items;
  int                  cycle_count;
  int                  send_idle_pct;
  int                  sink_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parse model
  // ---------------------------------------------------------------------------

  function automatic mqttps_pkg::ptype_e id_class(input logic [7:0] id);
    case (id)
      8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: return mqttps_pkg::PT_BYTE1;
      8'h13, 8'h21, 8'h22, 8'h23:                             return mqttps_pkg::PT_BYTE2;
      8'h02, 8'h11, 8'h18, 8'h27:                             return mqttps_pkg::PT_BYTE4;
      8'h0B:                                                  return mqttps_pkg::PT_VBI;
      8'h03, 8'h08, 8'h09, 8'h12, 8'h15, 8'h16, 8'h1A, 8'h1C, 8'h1F:
                                                              return mqttps_pkg::PT_STR;
      mqttps_pkg::USER_PROP_ID:                               return mqttps_pkg::PT_PAIR;
      default:                                                return mqttps_pkg::PT_UNKNOWN;
    endcase
  endfunction

  function automatic void clear_parser();
    sec_phase    = mqttps_pkg::PH_IDLE;
    sec_left     = '0;
    cur_id       = '0;
    num_acc      = '0;
    num_cnt      = '0;
    str_left     = '0;
    in_value_str = 1'b0;
  endfunction

  function automatic mqttps_pkg::result_t make_beat(input mqttps_pkg::kind_e k,
                                                    input logic [7:0] pay,
                                                    input logic second, input logic last,
                                                    input logic done,
                                                    input mqttps_pkg::status_e st);
    mqttps_pkg::result_t r;
    r.kind             = k;
    r.prop_id          = cur_id;
    r.value            = (k == mqttps_pkg::KIND_VALUE) ? num_acc : 32'd0;
    r.payload_byte     = (k == mqttps_pkg::KIND_PAYLOAD) ? pay : 8'h00;
    r.second_string    = second;
    r.last_of_property = last;
    r.section_done     = done;
    r.status           = st;
    return r;
  endfunction

  function automatic mqttps_pkg::result_t abort_section(input mqttps_pkg::status_e st);
    sec_phase = mqttps_pkg::PH_IDLE;
    return make_beat(mqttps_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1, st);
  endfunction

  // Last beat of a property; ends the section when nothing is left
  function automatic mqttps_pkg::result_t close_prop(input mqttps_pkg::kind_e k,
                                                     input logic [7:0] pay);
    logic done;
    logic second;
    done      = (sec_left == '0);
    second    = (k == mqttps_pkg::KIND_PAYLOAD || k == mqttps_pkg::KIND_EMPTY) ?
                in_value_str : 1'b0;
    sec_phase = done ? mqttps_pkg::PH_IDLE : mqttps_pkg::PH_ID;
    return make_beat(k, pay, second, 1'b1, done, mqttps_pkg::ST_OK);
  endfunction

  // End of a string; a user property's key string goes on to its value string
  function automatic mqttps_pkg::result_t string_close(input mqttps_pkg::kind_e k,
                                                       input logic [7:0] pay);
    if (cur_id == mqttps_pkg::USER_PROP_ID && !in_value_str) begin
      if (sec_left == '0) return abort_section(mqttps_pkg::ST_MALFORMED);
      sec_phase    = mqttps_pkg::PH_SLEN_HI;
      in_value_str = 1'b1;
      return make_beat(k, pay, 1'b0, 1'b0, 1'b0, mqttps_pkg::ST_OK);
    end
    return close_prop(k, pay);
  endfunction

  // Advances the model by one byte; returns 1 when a result beat is due
  function automatic bit parse_byte(input logic [7:0] b, input logic s,
                                    output mqttps_pkg::result_t r);
    r = '0;
    if (s) begin
      clear_parser();
      sec_phase = mqttps_pkg::PH_LEN;
    end
    if (sec_phase == mqttps_pkg::PH_IDLE) return 1'b0;

    // Section length, a variable byte integer
    if (sec_phase == mqttps_pkg::PH_LEN) begin
      num_acc = num_acc + (32'(b[6:0]) << (7 * num_cnt[1:0]));
      num_cnt = num_cnt + 3'd1;
      if (b[7]) begin
        if (num_cnt >= 3'd4) begin
          r = abort_section(mqttps_pkg::ST_MALFORMED);
          return 1'b1;
        end
        return 1'b0;
      end
      sec_left = num_acc[27:0];
      num_acc  = '0;
      num_cnt  = '0;
      if (sec_left == '0) begin
        sec_phase = mqttps_pkg::PH_IDLE;
        r = make_beat(mqttps_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1, mqttps_pkg::ST_OK);
        return 1'b1;
      end
      sec_phase = mqttps_pkg::PH_ID;
      return 1'b0;
    end

    if (sec_left == '0) begin
      r = abort_section(mqttps_pkg::ST_MALFORMED);
      return 1'b1;
    end
    sec_left = sec_left - 28'd1;

    case (sec_phase)
      mqttps_pkg::PH_ID: begin
        cur_id       = b;
        num_acc      = '0;
        num_cnt      = '0;
        in_value_str = 1'b0;
        case (id_class(b))
          mqttps_pkg::PT_UNKNOWN: begin
            r = abort_section(mqttps_pkg::ST_PROTO_ERR);
            return 1'b1;
          end
          mqttps_pkg::PT_BYTE1: begin
            num_cnt   = 3'd1;
            sec_phase = mqttps_pkg::PH_NUM;
          end
          mqttps_pkg::PT_BYTE2: begin
            num_cnt   = 3'd2;
            sec_phase = mqttps_pkg::PH_NUM;
          end
          mqttps_pkg::PT_BYTE4: begin
            num_cnt   = 3'd4;
            sec_phase = mqttps_pkg::PH_NUM;
          end
          mqttps_pkg::PT_VBI: sec_phase = mqttps_pkg::PH_VBI;
          default:            sec_phase = mqttps_pkg::PH_SLEN_HI;
        endcase
      end
      mqttps_pkg::PH_NUM: begin
        num_acc = {num_acc[23:0], b};
        num_cnt = num_cnt - 3'd1;
        if (num_cnt == '0) begin
          r = close_prop(mqttps_pkg::KIND_VALUE, 8'h00);
          return 1'b1;
        end
      end
      mqttps_pkg::PH_VBI: begin
        num_acc = num_acc + (32'(b[6:0]) << (7 * num_cnt[1:0]));
        num_cnt = num_cnt + 3'd1;
        if (!b[7]) begin
          r = close_prop(mqttps_pkg::KIND_VALUE, 8'h00);
          return 1'b1;
        end
        if (num_cnt >= 3'd4) begin
          r = abort_section(mqttps_pkg::ST_MALFORMED);
          return 1'b1;
        end
      end
      mqttps_pkg::PH_SLEN_HI: begin
        str_left  = {b, 8'h00};
        sec_phase = mqttps_pkg::PH_SLEN_LO;
      end
      mqttps_pkg::PH_SLEN_LO: begin
        str_left = {str_left[15:8], b};
        if (str_left == '0) begin
          r = string_close(mqttps_pkg::KIND_EMPTY, 8'h00);
          return 1'b1;
        end
        sec_phase = mqttps_pkg::PH_BODY;
      end
      mqttps_pkg::PH_BODY: begin
        str_left = str_left - 16'd1;
        if (str_left == '0) begin
          r = string_close(mqttps_pkg::KIND_PAYLOAD, b);
          return 1'b1;
        end
        if (sec_left == '0) begin
          r = abort_section(mqttps_pkg::ST_MALFORMED);
          return 1'b1;
        end
        r = make_beat(mqttps_pkg::KIND_PAYLOAD, b, in_value_str, 1'b0, 1'b0,
                      mqttps_pkg::ST_OK);
        return 1'b1;
      end
      default: begin
        sec_phase = mqttps_pkg::PH_IDLE;
        return 1'b0;
      end
    endcase

    // Property still needs bytes but the section is used up
    if (sec_left == '0) begin
      r = abort_section(mqttps_pkg::ST_MALFORMED);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0, 1:    return 0;
      2:       return 10;
      default: return 35;
    endcase
  endfunction

  // Byte with the extremes weighted up
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic mqttps_pkg::result_t status_beat(input logic [7:0] id,
                                                      input mqttps_pkg::status_e st);
    mqttps_pkg::result_t r;
    r              = '0;
    r.kind         = mqttps_pkg::KIND_STATUS;
    r.prop_id      = id;
    r.section_done = 1'b1;
    r.status       = st;
    return r;
  endfunction

  // Queue helpers: append at the tail
  function automatic void expect_beat(input mqttps_pkg::result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void put_sec(input logic [7:0] b);
    sec_bytes.insert(sec_bytes.size(), b);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, n_results, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_beat();
    mqttps_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("beat arrived with nothing expected");
    end else begin
      want = expected_q.pop_front();
      check_field("kind",             32'(res_ch.kind),             32'(want.kind));
      check_field("prop_id",          32'(res_ch.prop_id),          32'(want.prop_id));
      check_field("value",            res_ch.value,                 want.value);
      check_field("payload_byte",     32'(res_ch.payload_byte),     32'(want.payload_byte));
      check_field("second_string",    32'(res_ch.second_string),    32'(want.second_string));
      check_field("last_of_property", 32'(res_ch.last_of_property),
                  32'(want.last_of_property));
      check_field("section_done",     32'(res_ch.section_done),     32'(want.section_done));
      check_field("status",           32'(res_ch.status),           32'(want.status));
    end
    n_results++;
  endtask

  always @(posedge clk) begin
    if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_beat();
  end

  // Result side: random stalls, with windows of no stalls
  initial begin : sink_side
    int stall_left;
    int window;
    stall_left     = 0;
    window         = 0;
    sink_stall_pct = 0;
    res_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (window == 0) begin
        window         = $urandom_range(50, 300);
        sink_stall_pct = pick_pct();
      end
      window--;
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < sink_stall_pct) begin
        res_ch.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Holds one beat until accepted; an idle gap may come first
  task automatic drive_beat(input logic [7:0] b, input logic s);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = pick_gap();
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.start_req <= s;
    @(posedge clk);
    while (byte_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic s);
    mqttps_pkg::result_t r;
    bit live;
    drive_beat(b, s);
    live = s || (sec_phase != mqttps_pkg::PH_IDLE);
    if (parse_byte(b, s, r)) expect_beat(r);
    if (live) n_items++;
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Length-prefixed string, mostly short
  task automatic add_string();
    int n;
    case ($urandom_range(99))
      0:       n = $urandom_range(200, 300);
      1, 2, 3: n = $urandom_range(6, 20);
      default: n = $urandom_range(0, 5);
    endcase
    put_sec(8'(n >> 8));
    put_sec(8'(n));
    repeat (n) put_sec(rand_byte());
  endtask

  // One random section: well-formed mostly, sometimes broken
  task automatic send_section();
    logic [7:0] id;
    logic [7:0] head [$];
    int n_props;
    int nb;
    int len;
    int nlen;
    int pick;

    if ($urandom_range(4) == 0) send_idle_pct = pick_pct();
    sec_bytes = {};
    head      = {};

    // Properties
    n_props = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 4);
    for (int p = 0; p < n_props; p++) begin
      id = KNOWN_IDS[$urandom_range(26)];
      put_sec(id);
      case (id_class(id))
        mqttps_pkg::PT_BYTE1: put_sec(rand_byte());
        mqttps_pkg::PT_BYTE2: repeat (2) put_sec(rand_byte());
        mqttps_pkg::PT_BYTE4: repeat (4) put_sec(rand_byte());
        mqttps_pkg::PT_VBI: begin
          nb = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
          for (int i = 0; i < nb; i++)
            put_sec((rand_byte() & mqttps_pkg::VBI_MASK) |
                    ((i < nb - 1) ? mqttps_pkg::VBI_CONT : 8'h00));
        end
        mqttps_pkg::PT_PAIR: begin
          add_string();
          add_string();
        end
        default: add_string();
      endcase
    end
    if (sec_bytes.size() != 0 && $urandom_range(24) == 0)
      sec_bytes[$urandom_range(sec_bytes.size() - 1)] = 8'($urandom_range(255));

    // Declared length, sometimes off from the real one
    len  = sec_bytes.size();
    pick = $urandom_range(99);
    if (pick < 5 && len > 0) len = len - $urandom_range(1, len);
    else if (pick < 10)      len = len + $urandom_range(1, 3);

    if (pick >= 10 && pick < 13) begin
      // Four length bytes, all continued
      repeat (4) head.insert(head.size(), 8'($urandom_range(255)) | mqttps_pkg::VBI_CONT);
    end else if (pick >= 13 && pick < 16) begin
      // Very long section, cut short by the next start
      repeat (3) head.insert(head.size(), 8'($urandom_range(255)) | mqttps_pkg::VBI_CONT);
      head.insert(head.size(), 8'($urandom_range(1, 127)));
    end else begin
      nlen = 1;
      while (nlen < 4 && (len >> (7 * nlen)) != 0) nlen++;
      if ($urandom_range(3) == 0) nlen = $urandom_range(nlen, 4);
      for (int i = 0; i < nlen; i++)
        head.insert(head.size(), 8'((len >> (7 * i)) & 'h7f) |
                    ((i < nlen - 1) ? mqttps_pkg::VBI_CONT : 8'h00));
    end

    // Stray bytes without a start
    if ($urandom_range(19) == 0) repeat ($urandom_range(1, 3)) push_byte(rand_byte(), 1'b0);

    foreach (head[i]) push_byte(head[i], (i == 0));
    foreach (sec_bytes[i]) push_byte(sec_bytes[i], 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    mqttps_pkg::result_t r;
    bit yields;

    n_errors      = 0;
    n_results     = 0;
    n_items       = 0;
    send_idle_pct = 10;
    clear_parser();

    rst_n             <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.start_req <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data, start, typed, yields, expected beat
    dir_rows = '{
      '{8'hFF, 1'b0, 1'b1, 1'b0, '0},                          // idle byte, ignored
      '{8'h00, 1'b1, 1'b1, 1'b1, status_beat(8'h00, mqttps_pkg::ST_OK)},   // empty section
      '{8'hFF, 1'b1, 1'b1, 1'b0, '0},                          // length, continued
      '{8'hFF, 1'b0, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, 1'b1,
        status_beat(8'h00, mqttps_pkg::ST_MALFORMED)},         // fourth length byte
      '{8'h0A, 1'b1, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, 1'b0, '0},                          // one-byte property
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h06, 1'b1, 1'b1, 1'b0, '0},                          // restart mid-section
      '{8'h26, 1'b0, 1'b0, 1'b0, '0},                          // user property
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},                          // empty key
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, 1'b0, '0},
      '{8'hAB, 1'b0, 1'b0, 1'b0, '0},                          // value byte ends section
      '{8'h01, 1'b1, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, 1'b1,
        status_beat(8'h00, mqttps_pkg::ST_PROTO_ERR)},         // unknown ID
      '{8'h01, 1'b1, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b1, 1'b1,
        status_beat(8'h02, mqttps_pkg::ST_MALFORMED)},         // overrun
      '{8'h05, 1'b1, 1'b0, 1'b0, '0},
      '{8'h0B, 1'b0, 1'b0, 1'b0, '0},                          // VBI property
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, 1'b1,
        status_beat(8'h0B, mqttps_pkg::ST_MALFORMED)}          // fourth VBI byte
    };

    foreach (dir_rows[i]) begin
      drive_beat(dir_rows[i].data, dir_rows[i].start);
      yields = parse_byte(dir_rows[i].data, dir_rows[i].start, r);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].yields) expect_beat(dir_rows[i].want);
      end else if (yields) begin
        expect_beat(r);
      end
    end

    // Hold the sender until every result is out
    wait_drained();

    while (n_items < ITEM_TARGET) begin
      if ($urandom_range(49) == 0) wait_drained();
      send_section();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mqttps_pkg.sv
hdl/mqttps_if.sv
hdl/mqttps_step.sv
hdl/mqtt5_property_section_parser.sv
tb/sv/mqtt5_property_section_parser_tb.sv
